### design/bitmap_glyph_rect_emitter_assert.svh
// assertion shorthands shared by the rtl modules, clocked on aclk, off during reset
`ifndef BITMAP_GLYPH_RECT_EMITTER_ASSERT_SVH
`define BITMAP_GLYPH_RECT_EMITTER_ASSERT_SVH

// condition holds at every edge
`define BGRE_ASSERT(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define BGRE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/bgre_pkg.sv
package bgre_pkg;

    localparam int COORD_BITS_DEF  = 32;
    localparam int RECT_FIFO_DEPTH = 64;

    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_ROWS  = 9;
    localparam int GLYPH_BITS  = GLYPH_COLS * GLYPH_ROWS;
    localparam int FIRST_CODE  = 32;
    localparam int LAST_CODE   = 126;
    localparam int GLYPH_COUNT = LAST_CODE - FIRST_CODE + 1;

    localparam int APB_ADDR_W = 5;

    // register indexes, byte address is 4 times the index
    localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [2:0] REG_PIXEL_WIDTH  = 3'd2;
    localparam logic [2:0] REG_PIXEL_HEIGHT = 3'd3;
    localparam logic [2:0] REG_ADVANCE      = 3'd4;
    localparam logic [2:0] REG_COLOR        = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } scan_state_t;

    typedef struct packed {
        logic        last;
        logic [31:0] rect_color;
        logic [31:0] max_y;
        logic [31:0] max_x;
        logic [31:0] min_y;
        logic [31:0] min_x;
    } rect_t;

    // one glyph per entry, top row in the high bits, leftmost column first
    localparam logic [GLYPH_BITS-1:0] FONT_ROM [GLYPH_COUNT] = '{
        {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00},
        {5'h04,5'h04,5'h04,5'h04,5'h04,5'h00,5'h04,5'h00,5'h00},
        {5'h0A,5'h0A,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00},
        {5'h0A,5'h0A,5'h1F,5'h0A,5'h1F,5'h0A,5'h0A,5'h00,5'h00},
        {5'h04,5'h0F,5'h14,5'h0E,5'h05,5'h1E,5'h04,5'h00,5'h00},
        {5'h19,5'h19,5'h02,5'h04,5'h08,5'h13,5'h13,5'h00,5'h00},
        {5'h0C,5'h12,5'h14,5'h08,5'h15,5'h12,5'h0D,5'h00,5'h00},
        {5'h04,5'h04,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00},
        {5'h02,5'h04,5'h08,5'h08,5'h08,5'h08,5'h04,5'h02,5'h00},
        {5'h08,5'h04,5'h02,5'h02,5'h02,5'h02,5'h04,5'h08,5'h00},
        {5'h04,5'h15,5'h0E,5'h1F,5'h0E,5'h15,5'h04,5'h00,5'h00},
        {5'h00,5'h04,5'h04,5'h1F,5'h04,5'h04,5'h00,5'h00,5'h00},
        {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h04,5'h04,5'h08},
        {5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00,5'h00,5'h00},
        {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h04,5'h00},
        {5'h00,5'h01,5'h02,5'h04,5'h08,5'h10,5'h00,5'h00,5'h00},
        {5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E,5'h00,5'h00},
        {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h1F,5'h00,5'h00},
        {5'h0E,5'h11,5'h02,5'h04,5'h08,5'h10,5'h1F,5'h00,5'h00},
        {5'h0E,5'h11,5'h01,5'h0E,5'h01,5'h11,5'h0E,5'h00,5'h00},
        {5'h12,5'h12,5'h12,5'h1F,5'h02,5'h02,5'h02,5'h00,5'h00},
        {5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E,5'h00,5'h00},
        {5'h0E,5'h10,5'h10,5'h1E,5'h11,5'h11,5'h0E,5'h00,5'h00},
        {5'h1F,5'h01,5'h02,5'h04,5'h04,5'h04,5'h04,5'h00,5'h00},
        {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E,5'h00,5'h00},
        {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h01,5'h0E,5'h00,5'h00},
        {5'h00,5'h00,5'h04,5'h00,5'h04,5'h00,5'h00,5'h00,5'h00},
        {5'h00,5'h00,5'h04,5'h00,5'h04,5'h04,5'h08,5'h00,5'h00},
        {5'h02,5'h04,5'h08,5'h10,5'h08,5'h04,5'h02,5'h00,5'h00},
        {5'h00,5'h00,5'h1F,5'h00,5'h1F,5'h00,5'h00,5'h00,5'h00},
        {5'h08,5'h04,5'h02,5'h01,5'h02,5'h04,5'h08,5'h00,5'h00},
        {5'h0E,5'h11,5'h02,5'h04,5'h04,5'h00,5'h04,5'h00,5'h00},
        {5'h0E,5'h11,5'h13,5'h15,5'h17,5'h10,5'h0F,5'h00,5'h00},
        {5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11,5'h00,5'h00},
        {5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E,5'h00,5'h00},
        {5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E,5'h00,5'h00},
        {5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E,5'h00,5'h00},
        {5'h1F,5'h10,5'h10,5'h1C,5'h10,5'h10,5'h1F,5'h00,5'h00},
        {5'h1F,5'h10,5'h10,5'h1C,5'h10,5'h10,5'h10,5'h00,5'h00},
        {5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0E,5'h00,5'h00},
        {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11,5'h00,5'h00},
        {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h1F,5'h00,5'h00},
        {5'h0F,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0C,5'h00,5'h00},
        {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11,5'h00,5'h00},
        {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F,5'h00,5'h00},
        {5'h1B,5'h15,5'h15,5'h15,5'h11,5'h11,5'h11,5'h00,5'h00},
        {5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11,5'h00,5'h00},
        {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E,5'h00,5'h00},
        {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10,5'h00,5'h00},
        {5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D,5'h00,5'h00},
        {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11,5'h00,5'h00},
        {5'h0E,5'h11,5'h10,5'h0E,5'h01,5'h11,5'h0E,5'h00,5'h00},
        {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04,5'h00,5'h00},
        {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0F,5'h00,5'h00},
        {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04,5'h00,5'h00},
        {5'h11,5'h11,5'h11,5'h15,5'h15,5'h1B,5'h11,5'h00,5'h00},
        {5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11,5'h00,5'h00},
        {5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04,5'h00,5'h00},
        {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F,5'h00,5'h00},
        {5'h0E,5'h08,5'h08,5'h08,5'h08,5'h08,5'h0E,5'h00,5'h00},
        {5'h00,5'h10,5'h08,5'h04,5'h02,5'h01,5'h00,5'h00,5'h00},
        {5'h0E,5'h02,5'h02,5'h02,5'h02,5'h02,5'h0E,5'h00,5'h00},
        {5'h04,5'h0A,5'h11,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00},
        {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h1F},
        {5'h0C,5'h06,5'h02,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00},
        {5'h00,5'h00,5'h0E,5'h01,5'h0F,5'h11,5'h0F,5'h00,5'h00},
        {5'h10,5'h10,5'h1E,5'h11,5'h11,5'h11,5'h1E,5'h00,5'h00},
        {5'h00,5'h00,5'h0E,5'h11,5'h10,5'h11,5'h0E,5'h00,5'h00},
        {5'h01,5'h01,5'h0F,5'h11,5'h11,5'h11,5'h0F,5'h00,5'h00},
        {5'h00,5'h00,5'h0E,5'h11,5'h1F,5'h10,5'h0F,5'h00,5'h00},
        {5'h07,5'h08,5'h1E,5'h08,5'h08,5'h08,5'h08,5'h00,5'h00},
        {5'h00,5'h00,5'h0F,5'h11,5'h11,5'h11,5'h0F,5'h01,5'h1E},
        {5'h10,5'h10,5'h1E,5'h11,5'h11,5'h11,5'h11,5'h00,5'h00},
        {5'h04,5'h00,5'h0C,5'h04,5'h04,5'h04,5'h0E,5'h00,5'h00},
        {5'h02,5'h00,5'h0E,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0C},
        {5'h10,5'h10,5'h11,5'h12,5'h1C,5'h12,5'h11,5'h00,5'h00},
        {5'h0C,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E,5'h00,5'h00},
        {5'h00,5'h00,5'h1E,5'h15,5'h15,5'h15,5'h15,5'h00,5'h00},
        {5'h00,5'h00,5'h16,5'h19,5'h11,5'h11,5'h11,5'h00,5'h00},
        {5'h00,5'h00,5'h0E,5'h11,5'h11,5'h11,5'h0E,5'h00,5'h00},
        {5'h00,5'h00,5'h1E,5'h11,5'h11,5'h11,5'h1E,5'h10,5'h10},
        {5'h00,5'h00,5'h0F,5'h11,5'h11,5'h11,5'h0F,5'h01,5'h01},
        {5'h00,5'h00,5'h17,5'h18,5'h10,5'h10,5'h10,5'h00,5'h00},
        {5'h00,5'h00,5'h0F,5'h10,5'h0E,5'h01,5'h1E,5'h00,5'h00},
        {5'h08,5'h08,5'h1F,5'h08,5'h08,5'h08,5'h06,5'h00,5'h00},
        {5'h00,5'h00,5'h11,5'h11,5'h11,5'h11,5'h0F,5'h00,5'h00},
        {5'h00,5'h00,5'h11,5'h11,5'h11,5'h0A,5'h04,5'h00,5'h00},
        {5'h00,5'h00,5'h11,5'h11,5'h15,5'h15,5'h1B,5'h00,5'h00},
        {5'h00,5'h00,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h00,5'h00},
        {5'h00,5'h00,5'h11,5'h11,5'h0A,5'h04,5'h08,5'h10,5'h00},
        {5'h00,5'h00,5'h1F,5'h02,5'h04,5'h08,5'h1F,5'h00,5'h00},
        {5'h06,5'h08,5'h08,5'h10,5'h08,5'h08,5'h06,5'h00,5'h00},
        {5'h04,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04,5'h00},
        {5'h0C,5'h02,5'h02,5'h01,5'h02,5'h02,5'h0C,5'h00,5'h00},
        {5'h00,5'h0D,5'h12,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00}
    };

endpackage

### design/bgre_ram.sv
module bgre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/bgre_rect_fifo.sv
module bgre_rect_fifo #(
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     wr_en,
    input  bgre_pkg::rect_t          wr_rect,
    output logic [$clog2(DEPTH):0]   level,
    output logic                     m_valid,
    input  logic                     m_ready,
    output bgre_pkg::rect_t          m_rect
);

    import bgre_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int LW = AW + 1;

    logic [LW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [LW-1:0] rd_ptr_reg, rd_ptr_next;
    logic          pend_reg, pend_next;
    logic          out_valid_reg, out_valid_next;
    logic          skid_valid_reg, skid_valid_next;
    rect_t         out_rect_reg, out_rect_next;
    rect_t         skid_rect_reg, skid_rect_next;
    rect_t         rd_rect;
    logic          issue;
    logic          pop;

    bgre_ram #(
        .WIDTH ($bits(rect_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_ptr_reg[AW-1:0]),
        .wr_data (wr_rect),
        .rd_en   (issue),
        .rd_addr (rd_ptr_reg[AW-1:0]),
        .rd_data (rd_rect)
    );

    assign level = wr_ptr_reg - rd_ptr_reg;
    assign pop   = out_valid_reg & m_ready;

    // a read in flight needs a free slot in the output register or the skid register
    assign issue = (level != '0) && !skid_valid_reg && !(pend_reg && out_valid_reg && !pop);

    always_comb begin
        wr_ptr_next     = wr_ptr_reg + LW'(wr_en);
        rd_ptr_next     = rd_ptr_reg + LW'(issue);
        pend_next       = issue;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_rect_next   = out_rect_reg;
        skid_rect_next  = skid_rect_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                out_rect_next   = skid_rect_reg;
                skid_valid_next = 1'b0;
            end else if (pend_reg) begin
                out_rect_next = rd_rect;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (pend_reg) begin
            if (out_valid_reg) begin
                skid_rect_next  = rd_rect;
                skid_valid_next = 1'b1;
            end else begin
                out_rect_next  = rd_rect;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_rect_reg  <= out_rect_next;
        skid_rect_reg <= skid_rect_next;
    end

    assign m_valid = out_valid_reg;
    assign m_rect  = out_rect_reg;

`include "bitmap_glyph_rect_emitter_assert.svh"

    `BGRE_ASSERT(a_no_overflow, !wr_en || (level != LW'(DEPTH)), "rect fifo written while full")
    `BGRE_ASSERT(a_skid_needs_out, !skid_valid_reg || out_valid_reg, "skid holds data ahead of output")
    `BGRE_ASSERT(a_skid_no_read, !skid_valid_reg || !pend_reg, "ram read lands while skid is full")
    `BGRE_ASSERT_NEXT(a_stall_holds, out_valid_reg && !m_ready, out_valid_reg && $stable(out_rect_reg), "stalled rectangle changed")

endmodule

### design/bitmap_glyph_rect_emitter.sv
// Character generator with a fixed 5x9 bitmap font. Each input transaction carries one
// character code (s_tdata) and a restart flag (s_tuser) that puts the cursor back at
// origin_x first. Codes 32 to 126 are scanned cell by cell, row-major from the top row,
// one font cell per clock; every lit cell becomes one rectangle transaction with signed
// Q16.16 corners (saturated to COORD_BITS), and m_tlast marks the last rectangle of a
// glyph. Other codes and blank glyphs give no output. After every code the cursor moves
// right by advance. One character is taken at a time: the input is held while the scan
// loop steps cell by cell up to and including its last lit cell, and the scan pauses
// while the rectangle FIFO (FIFO_DEPTH entries, one RAM with registered read) is within
// two entries of full. A rectangle passes through stage a, stage b and the FIFO before it
// reaches the output, and the FIFO drains one rectangle per cycle while m_tready is high.
// Registers are written through the APB port at byte address 4*index and should be
// changed only while the block is idle.
module bitmap_glyph_rect_emitter #(
    parameter int COORD_BITS = bgre_pkg::COORD_BITS_DEF,
    parameter int FIFO_DEPTH = bgre_pkg::RECT_FIFO_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] char_code
    input  logic                              s_tuser,   // [0] restart
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [159:0]                      m_tdata,   // min_x, min_y, max_x, max_y, rect_color
    output logic                              m_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bgre_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    import bgre_pkg::*;

    localparam int SUM_W   = ((COORD_BITS > 35) ? COORD_BITS : 35) + 1;
    localparam int FIFO_LW = $clog2(FIFO_DEPTH) + 1;

    // clamp a wide signed sum to the signed coordinate range
    function automatic logic [COORD_BITS-1:0] sat_sum(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = {{(SUM_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
        lo = ~hi;
        if (s > hi) begin
            return hi[COORD_BITS-1:0];
        end else if (s < lo) begin
            return lo[COORD_BITS-1:0];
        end
        return s[COORD_BITS-1:0];
    endfunction

    function automatic logic signed [SUM_W-1:0] ext_c(input logic [COORD_BITS-1:0] c);
        return {{(SUM_W-COORD_BITS){c[COORD_BITS-1]}}, c};
    endfunction

    function automatic logic signed [SUM_W-1:0] ext_s32(input logic [31:0] v);
        return {{(SUM_W-32){v[31]}}, v};
    endfunction

    function automatic logic signed [SUM_W-1:0] ext_u(input logic [33:0] v);
        return {{(SUM_W-34){1'b0}}, v};
    endfunction

    // coordinate as a 32-bit output field
    function automatic logic [31:0] to_out(input logic [COORD_BITS-1:0] c);
        logic signed [SUM_W-1:0] w;
        w = ext_c(c);
        return w[31:0];
    endfunction

    // configuration registers
    logic [31:0] origin_x_reg;
    logic [31:0] origin_y_reg;
    logic [30:0] pixel_width_reg;
    logic [30:0] pixel_height_reg;
    logic [30:0] advance_reg;
    logic [31:0] color_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    // scanner
    scan_state_t             state_reg, state_next;
    logic [GLYPH_BITS-1:0]   remaining_reg, remaining_next;
    logic [2:0]              col_reg, col_next;
    logic [3:0]              row_reg, row_next;
    logic [COORD_BITS-1:0]   cursor_reg, cursor_next;
    logic [COORD_BITS-1:0]   cursor_use_reg, cursor_use_next;
    logic                    accept;
    logic                    drawable;
    logic [6:0]              glyph_idx;
    logic                    space_ok;
    logic                    step;
    logic                    lit;
    logic [3:0]              row_mul;

    // stage a: products, stage b: low corners
    logic                    a_valid_reg;
    logic                    a_last_reg;
    logic [33:0]             a_px_reg;
    logic [33:0]             a_py_reg;
    logic [COORD_BITS-1:0]   a_cursor_reg;
    logic                    b_valid_reg;
    logic                    b_last_reg;
    logic [COORD_BITS-1:0]   b_x0_reg;
    logic [COORD_BITS-1:0]   b_y0_reg;
    logic [COORD_BITS-1:0]   x1;
    logic [COORD_BITS-1:0]   y1;
    logic signed [SUM_W-1:0] x0_wide;
    logic signed [SUM_W-1:0] y0_wide;
    logic signed [SUM_W-1:0] x1_wide;
    logic signed [SUM_W-1:0] y1_wide;

    rect_t                   wr_rect;
    rect_t                   out_rect;
    logic [FIFO_LW-1:0]      fifo_level;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            pixel_width_reg  <= 31'd65536;
            pixel_height_reg <= 31'd65536;
            advance_reg      <= 31'd393216;
            color_reg        <= 32'hFFFF_FFFF;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ORIGIN_X:     origin_x_reg     <= pwdata;
                REG_ORIGIN_Y:     origin_y_reg     <= pwdata;
                REG_PIXEL_WIDTH:  pixel_width_reg  <= pwdata[30:0];
                REG_PIXEL_HEIGHT: pixel_height_reg <= pwdata[30:0];
                REG_ADVANCE:      advance_reg      <= pwdata[30:0];
                REG_COLOR:        color_reg        <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ORIGIN_X:     prdata = origin_x_reg;
            REG_ORIGIN_Y:     prdata = origin_y_reg;
            REG_PIXEL_WIDTH:  prdata = {1'b0, pixel_width_reg};
            REG_PIXEL_HEIGHT: prdata = {1'b0, pixel_height_reg};
            REG_ADVANCE:      prdata = {1'b0, advance_reg};
            REG_COLOR:        prdata = color_reg;
            default:          prdata = '0;
        endcase
    end

    // scan control
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid & s_tready;
    assign drawable  = (s_tdata >= 8'(FIRST_CODE)) && (s_tdata <= 8'(LAST_CODE));
    assign glyph_idx = 7'(s_tdata - 8'(FIRST_CODE));
    assign space_ok  = fifo_level <= FIFO_LW'(FIFO_DEPTH - 3);
    assign lit       = remaining_reg[GLYPH_BITS-1];
    assign step      = (state_reg == ST_SCAN) && (remaining_reg != '0) && space_ok;
    assign row_mul   = 4'(GLYPH_ROWS - 1) - row_reg;

    always_comb begin
        state_next      = state_reg;
        remaining_next  = remaining_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        cursor_next     = cursor_reg;
        cursor_use_next = cursor_use_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next      = ST_SCAN;
                    remaining_next  = drawable ? FONT_ROM[glyph_idx] : '0;
                    col_next        = '0;
                    row_next        = '0;
                    cursor_use_next = s_tuser ? sat_sum(ext_s32(origin_x_reg)) : cursor_reg;
                end
            end
            ST_SCAN: begin
                if (remaining_reg == '0) begin
                    // no lit cell left: step the cursor and take the next character
                    state_next  = ST_IDLE;
                    cursor_next = sat_sum(ext_c(cursor_use_reg) + ext_u({3'b000, advance_reg}));
                end else if (step) begin
                    remaining_next = {remaining_reg[GLYPH_BITS-2:0], 1'b0};
                    if (col_reg == 3'(GLYPH_COLS - 1)) begin
                        col_next = '0;
                        row_next = row_reg + 4'd1;
                    end else begin
                        col_next = col_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            remaining_reg <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            cursor_reg    <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            remaining_reg <= remaining_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            cursor_reg    <= cursor_next;
            a_valid_reg   <= step & lit;
            b_valid_reg   <= a_valid_reg;
        end
    end

    // coordinate pipeline
    assign x0_wide = ext_c(a_cursor_reg) + ext_u(a_px_reg);
    assign y0_wide = ext_s32(origin_y_reg) + ext_u(a_py_reg);
    assign x1_wide = ext_c(b_x0_reg) + ext_u({3'b000, pixel_width_reg});
    assign y1_wide = ext_c(b_y0_reg) + ext_u({3'b000, pixel_height_reg});
    assign x1      = sat_sum(x1_wide);
    assign y1      = sat_sum(y1_wide);

    always_ff @(posedge aclk) begin
        cursor_use_reg <= cursor_use_next;
        a_last_reg     <= lit && (remaining_reg[GLYPH_BITS-2:0] == '0);
        a_px_reg       <= {3'b000, pixel_width_reg} * {31'd0, col_reg};
        a_py_reg       <= {3'b000, pixel_height_reg} * {30'd0, row_mul};
        a_cursor_reg   <= cursor_use_reg;
        b_last_reg     <= a_last_reg;
        b_x0_reg       <= sat_sum(x0_wide);
        b_y0_reg       <= sat_sum(y0_wide);
    end

    always_comb begin
        wr_rect.min_x      = to_out(b_x0_reg);
        wr_rect.min_y      = to_out(b_y0_reg);
        wr_rect.max_x      = to_out(x1);
        wr_rect.max_y      = to_out(y1);
        wr_rect.rect_color = color_reg;
        wr_rect.last       = b_last_reg;
    end

    bgre_rect_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (b_valid_reg),
        .wr_rect (wr_rect),
        .level   (fifo_level),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_rect  (out_rect)
    );

    assign m_tdata = {out_rect.rect_color, out_rect.max_y, out_rect.max_x,
                      out_rect.min_y, out_rect.min_x};
    assign m_tlast = out_rect.last;

`include "bitmap_glyph_rect_emitter_assert.svh"

    `BGRE_ASSERT_NEXT(a_accept_scan, accept, state_reg == ST_SCAN, "accepted character did not start a scan")
    `BGRE_ASSERT(a_idle_clear, (state_reg != ST_IDLE) || (remaining_reg == '0), "idle with cells left")
    `BGRE_ASSERT_NEXT(a_scan_done, (state_reg == ST_SCAN) && (remaining_reg == '0), s_tready, "scan did not end")
    `BGRE_ASSERT(a_pipe_room, !b_valid_reg || (fifo_level != FIFO_LW'(FIFO_DEPTH)), "rectangle has no fifo room")

endmodule
